// ===== hw/rtl/sosf_pkg.sv =====
// Shared types, constants and arithmetic helpers for the state-space filter.
`timescale 1ns / 1ps

package sosf_pkg;

	// Field widths of the samples, states and coefficients.
	localparam int VAL_W   = 32;
	localparam int STEP_W  = 31;
	localparam int COEF_W  = 32;
	localparam int FRAC_SH = 24;
	localparam int PROD_W  = VAL_W + COEF_W;
	localparam int MULQ_W  = PROD_W - FRAC_SH;
	localparam int SUM_W   = MULQ_W + 2;

	// Configuration port geometry.
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_STEP_SIZE     = 2'd0;
	localparam logic [1:0] REG_POSITION_COEF = 2'd1;
	localparam logic [1:0] REG_RATE_COEF     = 2'd2;

	// Register reset values.
	localparam logic [STEP_W-1:0]        STEP_RESET      = 31'd1678;
	localparam logic signed [COEF_W-1:0] POS_COEF_RESET  = -32'sd75949282;
	localparam logic signed [COEF_W-1:0] RATE_COEF_RESET = -32'sd107089;

	// Rounding bias applied before the fixed-point shift.
	localparam logic signed [PROD_W-1:0] ROUND_BIAS = 64'sd8388608;

	// Saturation limits of a state value.
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	// Coefficient set held by the register block.
	typedef struct packed {
		logic [STEP_W-1:0]        step_size;
		logic signed [COEF_W-1:0] position_coef;
		logic signed [COEF_W-1:0] rate_coef;
	} cfg_t;

	// A clipped value together with its overflow flag.
	typedef struct packed {
		logic                    flag;
		logic signed [VAL_W-1:0] value;
	} clip_t;

	// Q16.16 times Q8.24, rounded half up back to Q16.16.
	function automatic logic signed [MULQ_W-1:0] mul_q(
		input logic signed [VAL_W-1:0]  val,
		input logic signed [COEF_W-1:0] coef
	);
		logic signed [PROD_W-1:0] prod;
		prod = PROD_W'(val) * PROD_W'(coef);
		prod = prod + ROUND_BIAS;
		return prod[PROD_W-1:FRAC_SH];
	endfunction

	// Clip a wide sum to the signed state range and flag any overflow.
	function automatic clip_t clip_sum(input logic signed [SUM_W-1:0] x);
		clip_t res;
		logic  in_range;
		in_range = (x[SUM_W-1:VAL_W-1] == '0) || (x[SUM_W-1:VAL_W-1] == '1);
		res.flag = !in_range;
		if (in_range) begin
			res.value = x[VAL_W-1:0];
		end else if (x[SUM_W-1]) begin
			res.value = VAL_MIN;
		end else begin
			res.value = VAL_MAX;
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/sosf_regs.sv =====
// Configuration register block with its APB-style access port.
`timescale 1ns / 1ps

module sosf_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sosf_pkg::ADDR_W-1:0] paddr,
	input  logic [sosf_pkg::DATA_W-1:0] pwdata,
	output logic [sosf_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output sosf_pkg::cfg_t              cfg
);
	import sosf_pkg::*;

	logic       wr_en;
	logic [1:0] reg_idx;
	cfg_t       cfg_q;

	// The port never inserts wait states.
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size     <= STEP_RESET;
			cfg_q.position_coef <= POS_COEF_RESET;
			cfg_q.rate_coef     <= RATE_COEF_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_STEP_SIZE:     cfg_q.step_size     <= pwdata[STEP_W-1:0];
				REG_POSITION_COEF: cfg_q.position_coef <= pwdata;
				REG_RATE_COEF:     cfg_q.rate_coef     <= pwdata;
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		unique case (reg_idx)
			REG_STEP_SIZE:     prdata = {1'b0, cfg_q.step_size};
			REG_POSITION_COEF: prdata = cfg_q.position_coef;
			REG_RATE_COEF:     prdata = cfg_q.rate_coef;
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/sosf_core.sv =====
// Euler update datapath: state registers that double as the result register.
`timescale 1ns / 1ps

module sosf_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  logic                              out_stall,
	input  logic signed [sosf_pkg::VAL_W-1:0] drive_s1,
	input  sosf_pkg::cfg_t                    cfg,
	output logic                              out_valid,
	output logic signed [sosf_pkg::VAL_W-1:0] out_voltage,
	output logic signed [sosf_pkg::VAL_W-1:0] out_rate,
	output logic                              saturated
);
	import sosf_pkg::*;

	logic signed [VAL_W-1:0]  volt_q;
	logic signed [VAL_W-1:0]  rate_q;
	logic                     sat_q;
	logic                     valid_q;
	logic signed [VAL_W:0]    diff_w;
	clip_t                    diff_c;
	logic signed [MULQ_W-1:0] step_term;
	logic signed [MULQ_W-1:0] pos_term;
	logic signed [MULQ_W-1:0] rate_term;
	logic signed [SUM_W-1:0]  volt_sum;
	logic signed [SUM_W-1:0]  rate_sum;
	clip_t                    volt_c;
	clip_t                    rate_c;

	// Voltage minus drive, clipped before it is scaled.
	assign diff_w = (VAL_W + 1)'(volt_q) - (VAL_W + 1)'(drive_s1);
	assign diff_c = clip_sum(SUM_W'(diff_w));

	// Three independent rounded products.
	assign step_term = mul_q(rate_q, $signed({1'b0, cfg.step_size}));
	assign pos_term  = mul_q(diff_c.value, cfg.position_coef);
	assign rate_term = mul_q(rate_q, cfg.rate_coef);

	// New states, each saturated to the state range.
	assign volt_sum = SUM_W'(volt_q) + SUM_W'(step_term);
	assign rate_sum = SUM_W'(rate_q) + SUM_W'(pos_term) + SUM_W'(rate_term);
	assign volt_c   = clip_sum(volt_sum);
	assign rate_c   = clip_sum(rate_sum);

	// State and result flag advance together on each update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_q <= '0;
			rate_q <= '0;
		end else if (fire) begin
			volt_q <= volt_c.value;
			rate_q <= rate_c.value;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sat_q <= diff_c.flag || volt_c.flag || rate_c.flag;
		end
	end

	// Result valid: set by an update, cleared when the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid   = valid_q;
	assign out_voltage = volt_q;
	assign out_rate    = rate_q;
	assign saturated   = sat_q;

endmodule

// ===== hw/rtl/second_order_state_space_filter.sv =====
// An item waits in the input register until the result register is empty or being emptied.
// Throughput: one item per cycle unless the output stalls; the state recurrence closes without a
// register through the clipped difference, one of three 32x32 multipliers and the saturating sum.
// Reset clears the voltage and rate states and the pipeline, and loads the coefficient
// registers with their default values.
`timescale 1ns / 1ps

module second_order_state_space_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sosf_pkg::ADDR_W-1:0]       paddr,
	input  logic [sosf_pkg::DATA_W-1:0]       pwdata,
	output logic [sosf_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [sosf_pkg::VAL_W-1:0] drive_sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [sosf_pkg::VAL_W-1:0] out_voltage,
	output logic signed [sosf_pkg::VAL_W-1:0] out_rate,
	output logic                              saturated
);
	import sosf_pkg::*;

	cfg_t                    cfg;
	logic                    valid_s1;
	logic signed [VAL_W-1:0] drive_s1;
	logic                    fire;
	logic                    in_take;

	sosf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// An item moves on when the result register is empty or being emptied.
	assign fire     = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && out_valid && out_stall;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			drive_s1 <= drive_sample;
		end
	end

	sosf_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.out_stall   (out_stall),
		.drive_s1    (drive_s1),
		.cfg         (cfg),
		.out_valid   (out_valid),
		.out_voltage (out_voltage),
		.out_rate    (out_rate),
		.saturated   (saturated)
	);

endmodule

// ===== hw/rtl/sosf_checker.sv =====
// Port-level checks for the state-space filter, bound to the top level.
`timescale 1ns / 1ps

module sosf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [sosf_pkg::VAL_W-1:0] out_voltage,
	input logic signed [sosf_pkg::VAL_W-1:0] out_rate,
	input logic                              saturated
);
	import sosf_pkg::*;

	// The input side is held back only by a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a waiting result");

	// An accepted item reaches the output, by way of the input register, if the output flows.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("result missing after accepted item");

	// A stalled result holds its values.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_voltage)
			&& $stable(out_rate) && $stable(saturated)))
		else $error("stalled result changed");

endmodule

bind second_order_state_space_filter sosf_checker u_sosf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_voltage (out_voltage),
	.out_rate    (out_rate),
	.saturated   (saturated)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the second-order state-space filter.
`timescale 1ns / 1ps

module tb;
	import sosf_pkg::*;

	// Register index with no register behind it; writes to it must be ignored.
	localparam logic [1:0] REG_SPARE = 2'd3;

	// One step of the filter as seen on the result side.
	typedef struct packed {
		logic signed [VAL_W-1:0] voltage;
		logic signed [VAL_W-1:0] rate;
		logic                    saturated;
	} step_result_t;

	// Tracks the filter state, predicts each Euler step and checks results in order.
	class euler_step_tracker;
		cfg_t                    coefs;
		logic signed [VAL_W-1:0] voltage;
		logic signed [VAL_W-1:0] rate;
		step_result_t            expected_steps[$];
		int                      errors;

		function new();
			coefs.step_size     = STEP_RESET;
			coefs.position_coef = POS_COEF_RESET;
			coefs.rate_coef     = RATE_COEF_RESET;
			voltage = '0;
			rate    = '0;
			errors  = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] data);
			case (idx)
				REG_STEP_SIZE:     coefs.step_size = data[STEP_W-1:0];
				REG_POSITION_COEF: coefs.position_coef = data;
				REG_RATE_COEF:     coefs.rate_coef = data;
				default: ;
			endcase
		endfunction

		// Clip to the signed 32-bit range, noting any overflow.
		function longint clamp(longint x, inout bit sat);
			if (x > longint'(VAL_MAX)) begin
				sat = 1'b1;
				return longint'(VAL_MAX);
			end
			if (x < longint'(VAL_MIN)) begin
				sat = 1'b1;
				return longint'(VAL_MIN);
			end
			return x;
		endfunction

		// Q16.16 times Q8.24, rounded half up back to Q16.16.
		function longint scale(longint val, longint coef);
			return (val * coef + ROUND_BIAS) >>> FRAC_SH;
		endfunction

		// Advance the state by one item and queue the step it should produce.
		function void note_drive(logic signed [VAL_W-1:0] drive);
			longint       v;
			longint       r;
			longint       diff;
			bit           sat;
			step_result_t e;
			v    = voltage;
			r    = rate;
			sat  = 1'b0;
			diff = clamp(v - longint'(drive), sat);
			e.voltage = VAL_W'(clamp(v + scale(r, longint'(coefs.step_size)), sat));
			e.rate    = VAL_W'(clamp(r + scale(diff, coefs.position_coef)
				+ scale(r, coefs.rate_coef), sat));
			e.saturated = sat;
			voltage = e.voltage;
			rate    = e.rate;
			expected_steps.push_back(e);
		endfunction

		function int pending();
			return expected_steps.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50)
				$display("%s", msg);
		endtask

		task check_result(logic signed [VAL_W-1:0] v, logic signed [VAL_W-1:0] r,
				logic s);
			step_result_t e;
			if (expected_steps.size() == 0) begin
				report($sformatf("result with nothing expected: voltage %0d rate %0d", v, r));
				return;
			end
			e = expected_steps.pop_front();
			if (v !== e.voltage)
				report($sformatf("out_voltage mismatch: got %0d, expected %0d", v, e.voltage));
			if (r !== e.rate)
				report($sformatf("out_rate mismatch: got %0d, expected %0d", r, e.rate));
			if (s !== e.saturated)
				report($sformatf("saturated mismatch: got %0b, expected %0b", s, e.saturated));
		endtask
	endclass

	logic                    clk;
	logic                    arst_n       = 1'b0;
	logic                    psel         = 1'b0;
	logic                    penable      = 1'b0;
	logic                    pwrite       = 1'b0;
	logic [ADDR_W-1:0]       paddr        = '0;
	logic [DATA_W-1:0]       pwdata       = '0;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    in_valid     = 1'b0;
	logic                    in_stall;
	logic signed [VAL_W-1:0] drive_sample = '0;
	logic                    out_valid;
	logic                    out_stall    = 1'b0;
	logic signed [VAL_W-1:0] out_voltage;
	logic signed [VAL_W-1:0] out_rate;
	logic                    saturated;

	bit                      idle_on      = 1'b1;
	int                      hold_left    = 0;
	euler_step_tracker       tracker;

	second_order_state_space_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.drive_sample(drive_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_voltage(out_voltage),
		.out_rate(out_rate),
		.saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: check every result that is taken, and stall in random bursts while idle_on is set.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			tracker.check_result(out_voltage, out_rate, saturated);
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			hold_left <= $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Register write: setup cycle and access cycle, then the bus goes idle.
	task automatic cfg_write(logic [1:0] idx, logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic load_coefs(logic [DATA_W-1:0] step, logic [DATA_W-1:0] pos,
			logic [DATA_W-1:0] rc);
		cfg_write(REG_STEP_SIZE, step);
		cfg_write(REG_POSITION_COEF, pos);
		cfg_write(REG_RATE_COEF, rc);
	endtask

	// Offer one drive sample, possibly after a short gap, and hold it until taken.
	task automatic feed_drive(logic signed [VAL_W-1:0] d);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		drive_sample <= d;
		do @(posedge clk); while (in_stall);
		tracker.note_drive(d);
	endtask

	// Stop sending and let every outstanding step come out.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int                      mode;
		int                      pick;
		logic signed [VAL_W-1:0] d;
		logic signed [VAL_W-1:0] last_d;
		tracker = new();
		last_d  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset coefficients: small steps, full-scale drives, clipped difference and sums.
		feed_drive(32'sd0);
		feed_drive(32'sd65536);
		feed_drive(32'sd65536);
		feed_drive(-32'sd1);
		feed_drive(32'sd1);
		feed_drive(32'sh7FFF_FFFF);
		feed_drive(32'sh8000_0000);
		feed_drive(32'sh8000_0000);
		feed_drive(32'sh7FFF_FFFF);
		feed_drive(32'sd0);
		feed_drive(-32'sd65536);
		feed_drive(32'sd0);

		// Extreme coefficients; the top data bit of the step write must be dropped.
		wait_idle();
		load_coefs(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		feed_drive(32'sd0);
		feed_drive(32'sh7FFF_FFFF);
		feed_drive(32'sh8000_0000);
		feed_drive(-32'sd1);
		feed_drive(32'sh5555_5555);
		feed_drive(32'sd0);

		// All coefficients zero, plus a write to the unused register slot.
		wait_idle();
		load_coefs(32'h0, 32'h0, 32'h0);
		cfg_write(REG_SPARE, $urandom);
		feed_drive(32'sh2AAA_AAAA);
		feed_drive(32'sd1);
		feed_drive(32'sh8000_0000);
		feed_drive(32'sh7FFF_FFFF);

		// Random phases, each loading a coefficient set; the first and last use the reset values, and the last runs flat out.
		for (int p = 0; p < 8; p++) begin
			wait_idle();
			idle_on <= (p == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
			mode = (p == 0 || p == 7) ? 0 : $urandom_range(0, 3);
			case (mode)
				0: load_coefs(DATA_W'(STEP_RESET), POS_COEF_RESET, RATE_COEF_RESET);
				2: load_coefs($urandom, $urandom, $urandom);
				default: load_coefs($urandom_range(0, 1 << 16),
					-int'($urandom_range(0, 1 << 27)),
					int'($urandom_range(0, 1 << 23)) - (1 << 22));
			endcase
			if ($urandom_range(0, 3) == 0)
				cfg_write(REG_SPARE, $urandom);
			for (int n = 0; n < 170; n++) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					d = int'($urandom_range(0, 2097151)) - 1048576;
				else if (pick < 8)
					d = $urandom;
				else
					d = last_d;
				last_d = d;
				feed_drive(d);
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("PASS second_order_state_space_filter");
		else
			$display("FAIL second_order_state_space_filter");
		$finish;
	end

	// Hard limit on the run length.
	initial begin
		#2_000_000;
		$display("FAIL second_order_state_space_filter");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/sosf_pkg.sv
hw/rtl/sosf_regs.sv
hw/rtl/sosf_core.sv
hw/rtl/second_order_state_space_filter.sv
hw/rtl/sosf_checker.sv
tb/tb.sv
